// ===== rtl/core/b32ge_pkg.sv =====
// b32ge_pkg: shared types, constants and the symbol table of the base32 grouped encoder.
// Depends on nothing; every other file of the encoder refers to it by scoped names.

package b32ge_pkg;

	// default block geometry
	localparam int BLOCK_BYTES_DEF   = 15;
	localparam int GROUP_SYMBOLS_DEF = 4;

	// one byte yields at most two symbols, each possibly preceded by a hyphen
	localparam int MAX_WORDS = 4;
	localparam int SLOT_W    = $clog2(MAX_WORDS);
	localparam int CNT_W     = $clog2(MAX_WORDS + 1);

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int CHAR_W = 7;

	typedef logic [CHAR_W-1:0] char_t;

	localparam char_t HYPHEN_CODE = 7'd45;
	localparam logic [4:0] SYMBOL_MASK = 5'h1f;

	// all words caused by one input byte
	typedef struct packed {
		char_t [MAX_WORDS-1:0] chars;
		logic  [CNT_W-1:0]     cnt;     // 1..MAX_WORDS
		logic                  closes;  // byte is the last of its block
	} entry_t;

	// Crockford alphabet, I L O U left out
	function automatic char_t sym_char(input logic [4:0] sym);
		char_t c;
		case (sym)
			5'd0:  c = 7'h30;  5'd1:  c = 7'h31;  5'd2:  c = 7'h32;  5'd3:  c = 7'h33;
			5'd4:  c = 7'h34;  5'd5:  c = 7'h35;  5'd6:  c = 7'h36;  5'd7:  c = 7'h37;
			5'd8:  c = 7'h38;  5'd9:  c = 7'h39;  5'd10: c = 7'h41;  5'd11: c = 7'h42;
			5'd12: c = 7'h43;  5'd13: c = 7'h44;  5'd14: c = 7'h45;  5'd15: c = 7'h46;
			5'd16: c = 7'h47;  5'd17: c = 7'h48;  5'd18: c = 7'h4a;  5'd19: c = 7'h4b;
			5'd20: c = 7'h4d;  5'd21: c = 7'h4e;  5'd22: c = 7'h50;  5'd23: c = 7'h51;
			5'd24: c = 7'h52;  5'd25: c = 7'h53;  5'd26: c = 7'h54;  5'd27: c = 7'h56;
			5'd28: c = 7'h57;  5'd29: c = 7'h58;  5'd30: c = 7'h59;  5'd31: c = 7'h5a;
			default: c = 7'h30;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/core/b32ge_if.sv =====
// b32ge_if: valid/ready channel interfaces of the encoder, byte side and character side.
// Depends on b32ge_pkg for the character type.

interface b32ge_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

interface b32ge_char_if;
	logic              valid;
	logic              ready;
	b32ge_pkg::char_t  character;
	logic              last_for_byte;
	logic              last_of_block;

	modport source (output valid, output character, output last_for_byte,
		output last_of_block, input ready);
	modport sink   (input valid, input character, input last_for_byte,
		input last_of_block, output ready);
endinterface

// ===== rtl/core/b32ge_front.sv =====
// b32ge_front: takes bytes, tracks the bit accumulator and block counters, and turns each
// byte into an entry of one to four words. Depends on b32ge_pkg.

module b32ge_front #(
	parameter int BLOCK_BYTES   = b32ge_pkg::BLOCK_BYTES_DEF,
	parameter int GROUP_SYMBOLS = b32ge_pkg::GROUP_SYMBOLS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid,
	input  logic [7:0]        data_byte,
	output logic              ready,
	input  logic              full,
	output logic              push,
	output b32ge_pkg::entry_t entry
);

	localparam int BT_W  = $clog2(BLOCK_BYTES);
	localparam int GRP_W = (GROUP_SYMBOLS > 1) ? $clog2(GROUP_SYMBOLS) : 1;
	localparam int CNT_W_L = b32ge_pkg::CNT_W;

	logic [3:0]       leftover_bits_q;
	logic [2:0]       leftover_count_q;
	logic [4:0]       symbols_written_q;
	logic [BT_W-1:0]  bytes_taken_q;
	logic [GRP_W-1:0] grp_q;   // symbols_written modulo the group size

	logic [11:0]      acc;
	logic [2:0]       bits0;
	logic [2:0]       bits1;
	logic             two;
	logic [2:0]       bits_fin;
	logic [4:0]       sym0;
	logic [4:0]       sym1;
	logic             hy0;
	logic             hy1;
	logic [GRP_W-1:0] grp1;
	logic [GRP_W-1:0] grp2;
	logic             closes;
	logic [4:0]       mask;
	logic [3:0]       lo_bits_nxt;
	logic [CNT_W_L-1:0] n;

	function automatic logic [GRP_W-1:0] grp_inc(input logic [GRP_W-1:0] g);
		logic [GRP_W-1:0] r;
		if (g == GRP_W'(GROUP_SYMBOLS - 1)) begin
			r = '0;
		end else begin
			r = g + GRP_W'(1);
		end
		return r;
	endfunction

	assign ready = !full;
	assign push  = valid && ready;

	// split the accumulator into one or two symbols
	always_comb begin
		acc    = {leftover_bits_q, data_byte};
		bits0  = leftover_count_q + 3'd3;          // leftover + 8 - 5
		two    = (bits0 >= 3'd5);
		bits1  = bits0 - 3'd5;
		bits_fin = two ? bits1 : bits0;
		sym0   = 5'(acc >> bits0) & b32ge_pkg::SYMBOL_MASK;
		sym1   = 5'(acc >> bits1) & b32ge_pkg::SYMBOL_MASK;
		grp1   = grp_inc(grp_q);
		grp2   = grp_inc(grp1);
		hy0    = (symbols_written_q != 5'd0) && (grp_q == '0);
		hy1    = two && (grp1 == '0);
		closes = (bytes_taken_q == BT_W'(BLOCK_BYTES - 1));
		mask   = (5'd1 << bits_fin) - 5'd1;
		lo_bits_nxt = acc[3:0] & mask[3:0];
	end

	// pack the words of this byte in order
	always_comb begin
		entry.chars = '0;
		n = '0;
		if (hy0) begin
			entry.chars[n[b32ge_pkg::SLOT_W-1:0]] = b32ge_pkg::HYPHEN_CODE;
			n = n + CNT_W_L'(1);
		end
		entry.chars[n[b32ge_pkg::SLOT_W-1:0]] = b32ge_pkg::sym_char(sym0);
		n = n + CNT_W_L'(1);
		if (two) begin
			if (hy1) begin
				entry.chars[n[b32ge_pkg::SLOT_W-1:0]] = b32ge_pkg::HYPHEN_CODE;
				n = n + CNT_W_L'(1);
			end
			entry.chars[n[b32ge_pkg::SLOT_W-1:0]] = b32ge_pkg::sym_char(sym1);
			n = n + CNT_W_L'(1);
		end
		entry.cnt    = n;
		entry.closes = closes;
	end

	// accumulator and block counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leftover_bits_q   <= '0;
			leftover_count_q  <= '0;
			symbols_written_q <= '0;
			bytes_taken_q     <= '0;
			grp_q             <= '0;
		end else if (push) begin
			if (closes) begin
				leftover_bits_q   <= '0;
				leftover_count_q  <= '0;
				symbols_written_q <= '0;
				bytes_taken_q     <= '0;
				grp_q             <= '0;
			end else begin
				leftover_bits_q   <= lo_bits_nxt;
				leftover_count_q  <= bits_fin;
				symbols_written_q <= symbols_written_q + (two ? 5'd2 : 5'd1);
				bytes_taken_q     <= bytes_taken_q + BT_W'(1);
				grp_q             <= two ? grp2 : grp1;
			end
		end
	end

endmodule

// ===== rtl/core/b32ge_queue.sv =====
// b32ge_queue: short FIFO of entries between the front and the back of the encoder.
// Depends on b32ge_pkg for the entry type and depth.

module b32ge_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  b32ge_pkg::entry_t wr_entry,
	output logic              full,
	input  logic              pop,
	output logic              not_empty,
	output b32ge_pkg::entry_t head
);

	localparam int DEPTH = b32ge_pkg::QUEUE_DEPTH;
	localparam int PW    = b32ge_pkg::QPTR_W;
	localparam int CW    = b32ge_pkg::QCNT_W;

	b32ge_pkg::entry_t mem_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     cnt_q;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		logic [PW-1:0] r;
		if (p == PW'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PW'(1);
		end
		return r;
	endfunction

	assign full      = (cnt_q == CW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// ===== rtl/core/b32ge_back.sv =====
// b32ge_back: walks the head entry into the output register one word per cycle unless
// the output is stalled, and raises the byte and block end flags. Depends on b32ge_pkg.

module b32ge_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                not_empty,
	input  b32ge_pkg::entry_t   head,
	output logic                pop,
	output logic                valid,
	input  logic                ready,
	output b32ge_pkg::char_t    character,
	output logic                last_for_byte,
	output logic                last_of_block
);

	localparam int SW = b32ge_pkg::SLOT_W;
	localparam int CW = b32ge_pkg::CNT_W;

	logic [SW-1:0]    idx_q;
	logic             vld_q;
	b32ge_pkg::char_t char_q;
	logic             lfb_q;
	logic             lob_q;
	logic             load;
	logic             last;

	// queue holds an entry and the output register is free or being drained this cycle
	assign load = not_empty && (!vld_q || ready);
	assign last = (CW'(idx_q) == head.cnt - CW'(1));
	assign pop  = load && last;

	assign valid         = vld_q;
	assign character     = char_q;
	assign last_for_byte = lfb_q;
	assign last_of_block = lob_q;

	// word payload
	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= head.chars[idx_q];
			lfb_q  <= last;
			lob_q  <= last && head.closes;
		end
	end

	// slot index and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			vld_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= last ? '0 : idx_q + SW'(1);
				vld_q <= 1'b1;
			end else if (ready) begin
				vld_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/base32_grouped_encoder_top.sv =====
// base32_grouped_encoder_top: Crockford base32 encoder with hyphen grouping, top level.
// Depends on b32ge_pkg, b32ge_if, b32ge_front, b32ge_queue and b32ge_back.
//
// Usage: raw bytes enter on byte_in (valid/ready, data_byte), MSB first. Each byte
// gives one or two base32 characters on char_out, with a hyphen before every symbol
// whose index in the block is a nonzero multiple of GROUP_SYMBOLS. last_for_byte
// marks the final word of a byte, last_of_block the final symbol of a block of
// BLOCK_BYTES bytes; after that byte all counters start over. Leftover bits at the
// end of a block are dropped, never padded.
// A byte's words pass through the queue and then the output register to char_out.
// Throughput: one output word per cycle while char_out.ready is high; a byte yields
// one to three words (four when GROUP_SYMBOLS is 1), and the output port sets the pace.
// A two-entry queue lets the input keep taking bytes while char_out is stalled;
// byte_in.ready drops only when that queue is full. A stalled word holds steady.
// Reset (arst_n low) empties the queue, drops any pending word and restarts the
// block; no clearing pass is needed.

module base32_grouped_encoder_top #(
	parameter int BLOCK_BYTES   = b32ge_pkg::BLOCK_BYTES_DEF,
	parameter int GROUP_SYMBOLS = b32ge_pkg::GROUP_SYMBOLS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	b32ge_byte_if.sink    byte_in,
	b32ge_char_if.source  char_out
);

	b32ge_pkg::entry_t fr_entry;
	b32ge_pkg::entry_t q_head;
	logic              fr_push;
	logic              q_full;
	logic              q_not_empty;
	logic              bk_pop;

	b32ge_front #(
		.BLOCK_BYTES   (BLOCK_BYTES),
		.GROUP_SYMBOLS (GROUP_SYMBOLS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (byte_in.valid),
		.data_byte (byte_in.data_byte),
		.ready     (byte_in.ready),
		.full      (q_full),
		.push      (fr_push),
		.entry     (fr_entry)
	);

	b32ge_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fr_push),
		.wr_entry  (fr_entry),
		.full      (q_full),
		.pop       (bk_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	b32ge_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.not_empty     (q_not_empty),
		.head          (q_head),
		.pop           (bk_pop),
		.valid         (char_out.valid),
		.ready         (char_out.ready),
		.character     (char_out.character),
		.last_for_byte (char_out.last_for_byte),
		.last_of_block (char_out.last_of_block)
	);

endmodule

// ===== rtl/core/b32ge_checker.sv =====
// b32ge_checker: port-level assertions for the base32 grouped encoder, and its bind.
// Depends on b32ge_pkg and binds into base32_grouped_encoder_top.

module b32ge_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_ready,
	input b32ge_pkg::char_t character,
	input logic             last_for_byte,
	input logic             last_of_block
);

	// a stalled word stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(character)
			&& $stable(last_for_byte) && $stable(last_of_block))
		else $error("output word changed while stalled");

	// only hyphen, digits and capitals leave the block
	a_legal_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (character == b32ge_pkg::HYPHEN_CODE)
			|| (character >= 7'h30 && character <= 7'h39)
			|| (character >= 7'h41 && character <= 7'h5a && character != 7'h49
				&& character != 7'h4c && character != 7'h4f && character != 7'h55))
		else $error("illegal output character");

	// a hyphen never ends a byte or a block; block end is always a byte end
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (character == b32ge_pkg::HYPHEN_CODE ? !last_for_byte && !last_of_block
			: (!last_of_block || last_for_byte)))
		else $error("end flags inconsistent with word");

	// nothing pending right after reset is released
	a_reset_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("output valid straight out of reset");

endmodule

bind base32_grouped_encoder_top b32ge_checker u_b32ge_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (char_out.valid),
	.out_ready     (char_out.ready),
	.character     (char_out.character),
	.last_for_byte (char_out.last_for_byte),
	.last_of_block (char_out.last_of_block)
);

// ===== bench/tb_base32_grouped_encoder_top.sv =====
// tb_base32_grouped_encoder_top: self-checking bench for the base32 grouped encoder.
// Depends on b32ge_pkg, b32ge_if and base32_grouped_encoder_top; a local encoder
// model predicts every output word, which is compared in order with the block output.

module tb_base32_grouped_encoder_top;

	localparam int BLOCK_LEN = b32ge_pkg::BLOCK_BYTES_DEF;
	localparam int GROUP_LEN = b32ge_pkg::GROUP_SYMBOLS_DEF;

	// symbol table, first character in the top byte
	localparam logic [255:0] CROCKFORD_TABLE = "0123456789ABCDEFGHJKMNPQRSTVWXYZ";

	typedef struct packed {
		b32ge_pkg::char_t ch;
		logic             last_byte;
		logic             last_block;
	} enc_word_t;

	logic clk;
	logic arst_n;

	b32ge_byte_if byte_ch ();
	b32ge_char_if char_ch ();

	base32_grouped_encoder_top #(
		.BLOCK_BYTES   (BLOCK_LEN),
		.GROUP_SYMBOLS (GROUP_LEN)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_in  (byte_ch),
		.char_out (char_ch)
	);

	// encoder model state
	logic [3:0] enc_bits;
	logic [2:0] enc_bit_cnt;
	logic [4:0] enc_sym_cnt;
	logic [3:0] enc_byte_cnt;

	enc_word_t pending_words [$];

	// bench control and bookkeeping
	logic tx_idle_en;
	logic rx_idle_en;
	int   rx_hold_cycles;
	int   error_count;
	int   bytes_accepted;
	int   words_checked;
	int   blocks_done;
	int   hyphens_seen;

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic b32ge_pkg::char_t sym_to_ascii(input logic [4:0] sym);
		return CROCKFORD_TABLE[(31 - sym) * 8 +: 7];
	endfunction

	// model: append one byte to the bit accumulator and queue the words it yields
	function automatic void encode_byte(input logic [7:0] b);
		logic [11:0] acc;
		logic [4:0]  sym;
		int          nbits;
		int          mask;
		logic        closes;
		logic        final_sym;
		enc_word_t   w;
		acc    = {enc_bits, b};
		nbits  = enc_bit_cnt + 8;
		closes = (enc_byte_cnt + 1) >= BLOCK_LEN;
		while (nbits >= 5) begin
			nbits = nbits - 5;
			if (enc_sym_cnt != 0 && (enc_sym_cnt % GROUP_LEN) == 0) begin
				w.ch         = b32ge_pkg::HYPHEN_CODE;
				w.last_byte  = 1'b0;
				w.last_block = 1'b0;
				pending_words.push_back(w);
			end
			sym          = 5'((acc >> nbits) & 12'(b32ge_pkg::SYMBOL_MASK));
			final_sym    = nbits < 5;
			w.ch         = sym_to_ascii(sym);
			w.last_byte  = final_sym;
			w.last_block = final_sym && closes;
			pending_words.push_back(w);
			enc_sym_cnt = enc_sym_cnt + 5'd1;
		end
		mask         = (1 << nbits) - 1;
		enc_bits     = acc[3:0] & mask[3:0];
		enc_bit_cnt  = nbits[2:0];
		enc_byte_cnt = enc_byte_cnt + 4'd1;
		if (closes) begin
			enc_bits     = '0;
			enc_bit_cnt  = '0;
			enc_sym_cnt  = '0;
			enc_byte_cnt = '0;
		end
	endfunction

	initial begin
		enc_bits     = '0;
		enc_bit_cnt  = '0;
		enc_sym_cnt  = '0;
		enc_byte_cnt = '0;
		error_count    = 0;
		bytes_accepted = 0;
		words_checked  = 0;
		blocks_done    = 0;
		hyphens_seen   = 0;
		rx_hold_cycles = 0;
		tx_idle_en     = 1'b1;
		rx_idle_en     = 1'b1;
	end

	// handshakes are sampled mid-cycle, where every signal is settled
	always @(negedge clk) begin : monitor
		enc_word_t exp_w;
		if (arst_n === 1'b1) begin
			if (byte_ch.valid && byte_ch.ready) begin
				encode_byte(byte_ch.data_byte);
				bytes_accepted++;
			end
			if (char_ch.valid && char_ch.ready) begin
				if (pending_words.size() == 0) begin
					$display("%0t: unexpected word: actual char %0d lfb %0b lob %0b", $time,
						char_ch.character, char_ch.last_for_byte, char_ch.last_of_block);
					error_count++;
				end else begin
					exp_w = pending_words.pop_front();
					words_checked++;
					if (exp_w.ch == b32ge_pkg::HYPHEN_CODE)
						hyphens_seen++;
					if (exp_w.last_block)
						blocks_done++;
					if (char_ch.character !== exp_w.ch) begin
						$display("%0t: character mismatch: expected %0d, actual %0d",
							$time, exp_w.ch, char_ch.character);
						error_count++;
					end
					if (char_ch.last_for_byte !== exp_w.last_byte) begin
						$display("%0t: last_for_byte mismatch: expected %0b, actual %0b",
							$time, exp_w.last_byte, char_ch.last_for_byte);
						error_count++;
					end
					if (char_ch.last_of_block !== exp_w.last_block) begin
						$display("%0t: last_of_block mismatch: expected %0b, actual %0b",
							$time, exp_w.last_block, char_ch.last_of_block);
						error_count++;
					end
				end
			end
		end
	end

	// output side: random stall per word, plus a long hold when a test asks for one
	initial begin : receiver
		int stall;
		char_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = rx_idle_en ? $urandom_range(0, 8) : 0;
			if (rx_hold_cycles > stall) begin
				stall          = rx_hold_cycles;
				rx_hold_cycles = 0;
			end
			if (stall > 0) begin
				char_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			char_ch.ready <= 1'b1;
			do @(negedge clk); while (!char_ch.valid);
			@(posedge clk);
		end
	end

	// offer one byte after a random gap and wait until it is taken
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = tx_idle_en ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_ch.valid     <= 1'b1;
		byte_ch.data_byte <= b;
		do @(negedge clk); while (!byte_ch.ready);
		@(posedge clk);
	endtask

	// stop offering and let every expected word come out
	task automatic wait_for_drain();
		byte_ch.valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// one full block plus the start of the next: all-zero, all-one, single bits,
	// alternating patterns; covers hyphen insertion and the end-of-block flag
	task automatic test_directed_patterns();
		logic [7:0] patterns [20] = '{
			8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F, 8'hFE, 8'hAA, 8'h55, 8'h0F, 8'hF0,
			8'h00, 8'hFF, 8'h84, 8'h21, 8'h08, 8'hFF, 8'hFF, 8'h00, 8'h5A, 8'hA5
		};
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		for (int i = 0; i < 10; i++)
			send_byte(patterns[i]);
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		for (int i = 10; i < 20; i++)
			send_byte(patterns[i]);
		wait_for_drain();
	endtask

	// random bytes over many blocks; idling on each side switched in stretches
	task automatic test_random_stream();
		logic [7:0] b;
		for (int i = 0; i < 300; i++) begin
			if (i % 50 == 0) begin
				tx_idle_en = ($urandom_range(0, 3) != 0);
				rx_idle_en = ($urandom_range(0, 3) != 0);
			end
			case ($urandom_range(0, 9))
				0:       b = 8'h00;
				1:       b = 8'hFF;
				default: b = 8'($urandom);
			endcase
			send_byte(b);
		end
		wait_for_drain();
	endtask

	// output held off for a long stretch while bytes keep coming back to back
	task automatic test_output_stall();
		tx_idle_en     = 1'b0;
		rx_idle_en     = 1'b0;
		rx_hold_cycles = 80;
		for (int i = 0; i < 30; i++)
			send_byte(8'($urandom));
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		wait_for_drain();
	endtask

	initial begin
		arst_n            = 1'b0;
		byte_ch.valid     <= 1'b0;
		byte_ch.data_byte <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_patterns();
		test_random_stream();
		test_output_stall();

		$display("Run covered %0d bytes in, %0d words checked (%0d hyphens), %0d blocks closed.",
			bytes_accepted, words_checked, hyphens_seen, blocks_done);
		$display("Stimulus mixed directed patterns, random bytes with both-side idling %s",
			"and a long output hold.");
		if (error_count == 0 && pending_words.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		#400000;
		$display("Timeout with %0d words still expected", pending_words.size());
		$display("Verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/b32ge_pkg.sv
rtl/core/b32ge_if.sv
rtl/core/b32ge_front.sv
rtl/core/b32ge_queue.sv
rtl/core/b32ge_back.sv
rtl/core/base32_grouped_encoder_top.sv
rtl/core/b32ge_checker.sv
bench/tb_base32_grouped_encoder_top.sv
